// ===== rtl/xxh_pkg.sv =====
`default_nettype none
package xxh_pkg;
    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    // multiplier request: a * b, low 64 bits
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STRIPE_M1,   // w*P2 for lane idx
        ST_STRIPE_M2,   // rotl(acc+..,31)*P1
        ST_MERGE_SUM,
        ST_MERGE_M1,    // lane*P2
        ST_MERGE_M2,    // rotl(..,31)*P1
        ST_MERGE_M3,    // h*P1
        ST_TOTAL,
        ST_WORD_M1,
        ST_WORD_M2,
        ST_WORD_M3,     // rotl(h,27)*P1
        ST_HALF_M1,     // part32*P1
        ST_HALF_M2,     // rotl(h,23)*P2
        ST_BYTE_M1,     // byte*P5
        ST_BYTE_M2,     // rotl(h,11)*P1
        ST_AVAL_M1,
        ST_AVAL_M2,
        ST_OUT
    } state_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] d;
        begin
            d = {x, x} << r;
            rotl = d[127:64];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/xxh_mul.sv =====
`default_nettype none
// 64x64 low product from the 32x32 partials that reach the low word, one per cycle; done pulses after the last.
module xxh_mul (
    input  wire                  clk,
    input  wire                  rst_n,
    input  xxh_pkg::mul_req_t    req,
    output xxh_pkg::mul_rsp_t    rsp
);
    import xxh_pkg::*;

    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic [31:0] x, y;
    logic [63:0] pp;

    always_comb
    begin
        x = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        y = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = {32'd0, x} * {32'd0, y};
        case (step_reg[1:0])
            2'd0:    acc_next = pp;
            2'd1:    acc_next = acc_reg + {pp[31:0], 32'd0};
            2'd2:    acc_next = acc_reg + {pp[31:0], 32'd0};
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 3'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd2)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (busy_reg)
            acc_reg <= acc_next;
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= busy_reg && step_reg == 3'd2 && !req.start;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg) else $error("mul restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without work");
`endif
endmodule
`default_nettype wire

// ===== rtl/xxh64_stream_hash_unit.sv =====
`default_nettype none
// xxh64_stream_hash_unit: XXH64 of a message streamed as 64-bit LE words.
// A non-final word is taken on its handshake; every fourth word folds a stripe,
// 4 lanes x 2 products of the shared multiplier, and no word is taken until the fold is done.
// Last word: merge, tail and avalanche run through the same multiplier;
// the new digest is held back while a previous digest still waits.
// Async active-low reset clears seed, counts and handshakes.
module xxh64_stream_hash_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [63:0] hash_seed,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [63:0] data_word,
    input  wire  [3:0]  byte_count,
    input  wire         last_word,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [63:0] digest
);
    import xxh_pkg::*;

    state_t      state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] buf_reg [4];
    logic [1:0]  nbuf_reg;
    logic [2:0]  nwords_reg;      // words left for tail at finish
    logic [63:0] total_reg;
    logic        seen_reg;
    logic [63:0] h_reg, t_reg, part_reg;
    logic [3:0]  n_reg;
    logic [1:0]  idx_reg;
    logic [63:0] dig_reg;
    logic        pend_reg;        // request posted to multiplier
    logic        out_valid_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    xxh_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign digest    = dig_reg;

    logic        acc_in;
    logic        out_free;        // digest register can take a new value
    logic [3:0]  nsat;
    assign acc_in   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign nsat     = (byte_count > 4'd8) ? 4'd8 : byte_count;

    logic [63:0] lane_init [4];
    assign lane_init[0] = seed_reg + P1 + P2;
    assign lane_init[1] = seed_reg + P2;
    assign lane_init[2] = seed_reg;
    assign lane_init[3] = seed_reg - P1;

    // multiplier operand selection per state
    always_comb
    begin
        mreq.a = 64'd0;
        mreq.b = P1;
        case (state_reg)
            ST_STRIPE_M1: begin mreq.a = buf_reg[idx_reg]; mreq.b = P2; end
            ST_STRIPE_M2: begin mreq.a = rotl(t_reg, 6'd31); mreq.b = P1; end
            ST_MERGE_M1:  begin mreq.a = lane_reg[idx_reg]; mreq.b = P2; end
            ST_MERGE_M2:  begin mreq.a = rotl(t_reg, 6'd31); mreq.b = P1; end
            ST_MERGE_M3:  begin mreq.a = h_reg; mreq.b = P1; end
            ST_WORD_M1:   begin mreq.a = buf_reg[idx_reg]; mreq.b = P2; end
            ST_WORD_M2:   begin mreq.a = rotl(t_reg, 6'd31); mreq.b = P1; end
            ST_WORD_M3:   begin mreq.a = rotl(h_reg, 6'd27); mreq.b = P1; end
            ST_HALF_M1:   begin mreq.a = {32'd0, part_reg[31:0]}; mreq.b = P1; end
            ST_HALF_M2:   begin mreq.a = rotl(h_reg, 6'd23); mreq.b = P2; end
            ST_BYTE_M1:   begin mreq.a = {56'd0, part_reg[7:0]}; mreq.b = P5; end
            ST_BYTE_M2:   begin mreq.a = rotl(h_reg, 6'd11); mreq.b = P1; end
            ST_AVAL_M1:   begin mreq.a = h_reg ^ (h_reg >> 33); mreq.b = P2; end
            ST_AVAL_M2:   begin mreq.a = h_reg ^ (h_reg >> 29); mreq.b = P3; end
            default:      begin mreq.a = 64'd0; mreq.b = P1; end
        endcase
        mreq.start = !pend_reg && (state_reg != ST_IDLE) && (state_reg != ST_MERGE_SUM)
                     && (state_reg != ST_TOTAL) && (state_reg != ST_OUT);
    end

    logic go;      // multiplier result ready this cycle
    assign go = pend_reg && mrsp.done;

    // tail dispatch after length add / word steps
    function automatic state_t after_words(input logic [2:0] nw, input logic [3:0] n);
        begin
            if (nw != 3'd0)       after_words = ST_WORD_M1;
            else if (n >= 4'd4)   after_words = ST_HALF_M1;
            else if (n != 4'd0)   after_words = ST_BYTE_M1;
            else                  after_words = ST_AVAL_M1;
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (acc_in)
                begin
                    // a full last word that completes a stripe finishes after it
                    if (!last_word || nsat == 4'd8)
                        state_next = (nbuf_reg == 2'd3) ? ST_STRIPE_M1
                                   : (last_word ? (seen_reg ? ST_MERGE_SUM : ST_TOTAL)
                                                : ST_IDLE);
                    else
                        state_next = seen_reg ? ST_MERGE_SUM : ST_TOTAL;
                end
            ST_STRIPE_M1: if (go) state_next = ST_STRIPE_M2;
            ST_STRIPE_M2: if (go) state_next = (idx_reg == 2'd3)
                              ? (n_reg[3] ? ST_MERGE_SUM : ST_IDLE) : ST_STRIPE_M1;
            ST_MERGE_SUM: state_next = ST_MERGE_M1;
            ST_MERGE_M1:  if (go) state_next = ST_MERGE_M2;
            ST_MERGE_M2:  if (go) state_next = ST_MERGE_M3;
            ST_MERGE_M3:  if (go) state_next = (idx_reg == 2'd3) ? ST_TOTAL : ST_MERGE_M1;
            ST_TOTAL:     state_next = after_words(nwords_reg, n_reg);
            ST_WORD_M1:   if (go) state_next = ST_WORD_M2;
            ST_WORD_M2:   if (go) state_next = ST_WORD_M3;
            ST_WORD_M3:   if (go) state_next = after_words(nwords_reg - 3'd1, n_reg);
            ST_HALF_M1:   if (go) state_next = ST_HALF_M2;
            ST_HALF_M2:   if (go) state_next = after_words(3'd0, n_reg - 4'd4);
            ST_BYTE_M1:   if (go) state_next = ST_BYTE_M2;
            ST_BYTE_M2:   if (go) state_next = after_words(3'd0, n_reg - 4'd1);
            ST_AVAL_M1:   if (go) state_next = ST_AVAL_M2;
            ST_AVAL_M2:   if (go) state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 64'd0;
            nbuf_reg      <= 2'd0;
            total_reg     <= 64'd0;
            seen_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            n_reg         <= 4'd0;
            nwords_reg    <= 3'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_reg <= hash_seed;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (mreq.start)
                pend_reg <= 1'b1;
            else if (go)
                pend_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in)
                    begin
                        idx_reg <= 2'd0;
                        if (!last_word || nsat == 4'd8)
                        begin
                            nbuf_reg  <= nbuf_reg + 2'd1;
                            total_reg <= total_reg + 64'd8;
                            part_reg  <= 64'd0;
                            n_reg     <= (last_word && nbuf_reg == 2'd3) ? 4'd8 : 4'd0;
                            nwords_reg <= (nbuf_reg == 2'd3) ? 3'd0 : {1'b0, nbuf_reg} + 3'd1;
                            if (nbuf_reg == 2'd3 && !seen_reg)
                            begin
                                seen_reg <= 1'b1;
                                for (int i = 0; i < 4; i++)
                                    lane_reg[i] <= lane_init[i];
                            end
                        end
                        else
                        begin
                            // tail bytes; bits above the count are never reached
                            part_reg   <= data_word;
                            n_reg      <= nsat;
                            total_reg  <= total_reg + {60'd0, nsat};
                            nwords_reg <= {1'b0, nbuf_reg};
                        end
                    end
                end
                ST_STRIPE_M1: if (go) t_reg <= lane_reg[idx_reg] + mrsp.p;
                ST_STRIPE_M2:
                    if (go)
                    begin
                        lane_reg[idx_reg] <= mrsp.p;
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                            n_reg <= 4'd0;
                    end
                ST_MERGE_SUM:
                begin
                    h_reg <= rotl(lane_reg[0], 6'd1) + rotl(lane_reg[1], 6'd7)
                           + rotl(lane_reg[2], 6'd12) + rotl(lane_reg[3], 6'd18);
                    idx_reg <= 2'd0;
                end
                ST_MERGE_M1: if (go) t_reg <= mrsp.p;
                ST_MERGE_M2: if (go) h_reg <= h_reg ^ mrsp.p;
                ST_MERGE_M3:
                    if (go)
                    begin
                        h_reg   <= mrsp.p + P4;
                        idx_reg <= idx_reg + 2'd1;
                    end
                ST_TOTAL:
                begin
                    h_reg   <= (seen_reg ? h_reg : seed_reg + P5) + total_reg;
                    idx_reg <= 2'd0;
                end
                ST_WORD_M1: if (go) t_reg <= mrsp.p;
                ST_WORD_M2: if (go) h_reg <= h_reg ^ mrsp.p;
                ST_WORD_M3:
                    if (go)
                    begin
                        h_reg      <= mrsp.p + P4;
                        idx_reg    <= idx_reg + 2'd1;
                        nwords_reg <= nwords_reg - 3'd1;
                    end
                ST_HALF_M1: if (go) h_reg <= h_reg ^ mrsp.p;
                ST_HALF_M2:
                    if (go)
                    begin
                        h_reg    <= mrsp.p + P3;
                        part_reg <= part_reg >> 32;
                        n_reg    <= n_reg - 4'd4;
                    end
                ST_BYTE_M1: if (go) h_reg <= h_reg ^ mrsp.p;
                ST_BYTE_M2:
                    if (go)
                    begin
                        h_reg    <= mrsp.p;
                        part_reg <= part_reg >> 8;
                        n_reg    <= n_reg - 4'd1;
                    end
                ST_AVAL_M1: if (go) h_reg <= mrsp.p;
                ST_AVAL_M2: if (go) h_reg <= mrsp.p;
                ST_OUT:
                begin
                    // hold here while the previous digest is still waiting
                    if (out_free)
                        dig_reg <= h_reg ^ (h_reg >> 32);
                    nbuf_reg      <= 2'd0;
                    total_reg     <= 64'd0;
                    seen_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // full message words into the stripe buffer
    always_ff @(posedge clk)
    begin
        if (acc_in && (!last_word || nsat == 4'd8))
            buf_reg[nbuf_reg] <= data_word;
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT) else $error("stray digest");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(dig_reg))
        else $error("digest dropped");
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> nbuf_reg == 2'd0 && !seen_reg) else $error("state not cleared");
`endif
endmodule
`default_nettype wire

// ===== test/xxh64_stream_hash_unit_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xxh64_stream_hash_unit_tb;
    import xxh_pkg::*;

    // Request as it goes to the hashing unit.
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        known;     // digest typed in below
        logic [63:0] digest;
    } word_req_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] hash_seed;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest;

    xxh64_stream_hash_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .hash_seed  (hash_seed),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest     (digest)
    );

    // Golden model state: the seed plus per-message lanes, stripe and length.
    logic [63:0] gm_seed;
    logic [63:0] gm_lane [4];
    logic [63:0] gm_stripe [4];
    int unsigned gm_nwords;
    logic [63:0] gm_len;
    logic        gm_started;

    logic [63:0] digest_q [$];
    int          errors;
    int          digests_seen;
    int          words_sent;
    int          messages_sent;

    function automatic logic [63:0] rol(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
        logic [63:0] a;
        a = acc + w * P2;
        return rol(a, 31) * P1;
    endfunction

    function automatic void gm_clear();
        gm_nwords  = 0;
        gm_len     = '0;
        gm_started = 1'b0;
    endfunction

    function automatic void gm_push(input logic [63:0] w);
        gm_stripe[gm_nwords] = w;
        gm_nwords++;
        gm_len += 64'd8;
        if (gm_nwords == 4) begin
            if (!gm_started) begin
                gm_lane[0] = gm_seed + P1 + P2;
                gm_lane[1] = gm_seed + P2;
                gm_lane[2] = gm_seed;
                gm_lane[3] = gm_seed - P1;
                gm_started = 1'b1;
            end
            for (int i = 0; i < 4; i++)
                gm_lane[i] = lane_mix(gm_lane[i], gm_stripe[i]);
            gm_nwords = 0;
        end
    endfunction

    // Feed one word into the golden model; a last word queues its digest.
    function automatic void hash_word(input logic [63:0] w, input logic [3:0] cnt,
                                      input logic last);
        logic [63:0] h;
        logic [63:0] part;
        int unsigned n;
        if (!last) begin
            gm_push(w);
            return;
        end
        n    = cnt;
        part = '0;
        if (n >= 8) begin
            gm_push(w);
            n = 0;
        end else if (n > 0) begin
            part = w & ((64'd1 << (8 * n)) - 64'd1);
        end
        if (gm_started) begin
            h = rol(gm_lane[0], 1) + rol(gm_lane[1], 7) + rol(gm_lane[2], 12)
              + rol(gm_lane[3], 18);
            for (int i = 0; i < 4; i++) begin
                h ^= lane_mix(64'd0, gm_lane[i]);
                h = h * P1 + P4;
            end
        end else begin
            h = gm_seed + P5;
        end
        h += gm_len + 64'(n);
        for (int i = 0; i < gm_nwords; i++) begin
            h ^= lane_mix(64'd0, gm_stripe[i]);
            h = rol(h, 27) * P1 + P4;
        end
        if (n >= 4) begin
            h ^= (part & 64'hFFFF_FFFF) * P1;
            h = rol(h, 23) * P2 + P3;
            part >>= 32;
            n -= 4;
        end
        while (n > 0) begin
            h ^= (part & 64'hFF) * P5;
            h = rol(h, 11) * P1;
            part >>= 8;
            n--;
        end
        h ^= h >> 33;
        h *= P2;
        h ^= h >> 29;
        h *= P3;
        h ^= h >> 32;
        digest_q.push_back(h);
        gm_clear();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d digests still pending", digest_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: stall pattern of its own, a quiet stretch every so often.
    int unsigned rx_cycle;
    always @(negedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if ((rx_cycle / 300) % 4 == 3)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 9) > 3);
        rx_cycle <= rx_cycle + 1;
    end

    // Check every accepted digest against the oldest prediction.
    logic [63:0] want_hold;
    logic        known_hold [$];
    logic [63:0] typed_hold [$];
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest", digest, '0);
            end else begin
                want_hold = digest_q.pop_front();
                if (digest !== want_hold)
                    report_mismatch("digest", digest, want_hold);
                if (known_hold.size() > 0) begin
                    if (known_hold[0] && digest !== typed_hold[0])
                        report_mismatch("typed digest", digest, typed_hold[0]);
                    void'(known_hold.pop_front());
                    void'(typed_hold.pop_front());
                end
                digests_seen++;
            end
        end
    end

    // Present one request and hold it until the handshake.
    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt,
                             input logic last, input logic known,
                             input logic [63:0] typed);
        in_valid   <= 1'b1;
        data_word  <= w;
        byte_count <= cnt;
        last_word  <= last;
        do @(posedge clk); while (!in_ready);
        hash_word(w, cnt, last);
        if (last) begin
            known_hold.push_back(known);
            typed_hold.push_back(typed);
            messages_sent++;
        end
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        cfg_valid <= 1'b1;
        hash_seed <= s;
        do @(posedge clk); while (!cfg_ready);
        gm_seed = s;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pause until all digests are back, then let the unit settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // Burst/gap sender for the random part.
    int unsigned burst_left;
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic random_message(input int unsigned nfull);
        logic [63:0] w;
        for (int i = 0; i < nfull; i++) begin
            pace();
            w = {$urandom, $urandom};
            // count on a non-last word is ignored: exercise any value
            send_word(w, 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0);
        end
        pace();
        w = {$urandom, $urandom};
        send_word(w, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 8)),
                  1'b1, 1'b0, '0);
    endtask

    word_req_t dir_tbl [$];

    initial begin
        errors = 0; digests_seen = 0; words_sent = 0; messages_sent = 0;
        burst_left = 0; rx_cycle = 0;
        rst_n = 1'b0; cfg_valid = 1'b0; hash_seed = '0;
        in_valid = 1'b0; data_word = '0; byte_count = '0; last_word = 1'b0;
        gm_seed = '0;
        for (int i = 0; i < 4; i++) begin
            gm_lane[i] = '0;
            gm_stripe[i] = '0;
        end
        gm_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: seed 0 after reset. Empty message is the well-known
        // XXH64("") = ef46db3751d8e999.
        dir_tbl = '{
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 64'hEF46_DB37_51D8_E999},
            '{64'h0000_0000_0000_0061, 4'd1, 1'b1, 1'b0, '0},   // "a"
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1, 1'b0, '0},   // half tail
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 1'b0, '0},   // half + bytes
            '{64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b0, '0},   // full last
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0, '0},  // saturates
            '{64'hA5A5_A5A5_A5A5_A5A5, 4'd3, 1'b0, 1'b0, '0},   // count ignored
            '{64'h5A5A_5A5A_5A5A_5A5A, 4'd8, 1'b0, 1'b0, '0},
            '{64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1'b0, '0},
            '{64'hFEDC_BA98_7654_3210, 4'd8, 1'b0, 1'b0, '0},   // stripe folds
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b0, '0},   // merge only
            '{64'h1111_1111_1111_1111, 4'd8, 1'b0, 1'b0, '0},
            '{64'h2222_2222_2222_2222, 4'd8, 1'b0, 1'b0, '0},
            '{64'h3333_3333_3333_3333, 4'd8, 1'b0, 1'b0, '0},
            '{64'h4444_4444_4444_4444, 4'd8, 1'b0, 1'b0, '0},
            '{64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0, '0},
            '{64'h0000_00FF_FFFF_FFFF, 4'd5, 1'b1, 1'b0, '0}    // stripe + word + tail
        };
        foreach (dir_tbl[i])
            send_word(dir_tbl[i].word, dir_tbl[i].nbytes, dir_tbl[i].last,
                      dir_tbl[i].known, dir_tbl[i].digest);
        drain();

        // Seed extremes, then random seeds; every phase mostly short messages.
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_word(64'h0, 4'd0, 1'b1, 1'b0, '0);
        for (int m = 0; m < 4; m++) random_message($urandom_range(0, 9));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_seed(ph == 0 ? 64'd0 : {$urandom, $urandom});
            for (int m = 0; m < 25; m++)
                random_message(($urandom_range(0, 15) == 0) ? $urandom_range(16, 40)
                                                            : $urandom_range(0, 9));
            drain();
        end

        repeat (250) @(posedge clk);
        $display("Hashed %0d messages from %0d words over 8 seed settings;",
                 messages_sent, words_sent);
        $display("%0d digests checked, %0d mismatches.", digests_seen, errors);
        if (errors == 0 && digest_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
